[hw/rtl/dbas_pkg.sv]
// ----------------------------------------------------------------------------
// dbas_pkg
// Shared constants, pixel and divider types for the depth block average
// subsample unit.
// ----------------------------------------------------------------------------
package dbas_pkg;

    // line buffer geometry and depth format
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DEPTH_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

    // configuration register widths
    localparam int DIM_BITS      = 11;
    localparam int DIST_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // position compare width: holds a clamped size and a counter plus one
    localparam int POS_A    = (ADDR_BITS > ROW_BITS) ? ADDR_BITS + 1 : ROW_BITS + 1;
    localparam int POS_BITS = (POS_A > DIM_BITS) ? POS_A : DIM_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DISTANCE = 2'd2;

    // register reset values
    localparam logic [DIM_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [DIM_BITS-1:0]  RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [DIST_BITS-1:0] RST_MAX_DISTANCE = 16'd30;

    // window and divider sizing
    localparam int WIN_SIZE    = 9;
    localparam int WIN_COLS    = 6;
    localparam int CNT_BITS    = $clog2(WIN_SIZE + 1);
    localparam int SUM_BITS    = DEPTH_BITS + CNT_BITS;
    localparam int RECIP_SHIFT = SUM_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;

    // reciprocals floor(2^shift / n) for counts 1..9
    localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 1);
    localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 2);
    localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 3);
    localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 4);
    localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 5);
    localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 6);
    localparam logic [RECIP_BITS-1:0] RECIP_7 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 7);
    localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 8);
    localparam logic [RECIP_BITS-1:0] RECIP_9 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 9);

    // one stored pixel: measured flag and depth
    typedef struct packed {
        logic                  vld;
        logic [DEPTH_BITS-1:0] dep;
    } t_pix;

    // line buffer word: pixel two rows up and one row up
    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_line_word;

    // divider request and response
    typedef struct packed {
        logic                vld;
        logic [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0] cnt;
    } t_div_req;

    typedef struct packed {
        logic                  vld;
        logic [DEPTH_BITS-1:0] quot;
    } t_div_rsp;

    // reciprocal lookup, a zero count is served as one
    function automatic logic [RECIP_BITS-1:0] f_recip(input logic [CNT_BITS-1:0] cnt);
        logic [RECIP_BITS-1:0] r;
        case (cnt)
            4'd2:    r = RECIP_2;
            4'd3:    r = RECIP_3;
            4'd4:    r = RECIP_4;
            4'd5:    r = RECIP_5;
            4'd6:    r = RECIP_6;
            4'd7:    r = RECIP_7;
            4'd8:    r = RECIP_8;
            4'd9:    r = RECIP_9;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/dbas_pix_if.sv]
// ----------------------------------------------------------------------------
// dbas_pix_if
// Input pixel channel: one depth sample with its measured flag per beat.
// ----------------------------------------------------------------------------
interface dbas_pix_if;
    logic                           valid;
    logic                           ready;
    logic [dbas_pkg::DEPTH_BITS-1:0] depth;
    logic                           valid_req;

    modport source (output valid, depth, valid_req, input ready);
    modport sink   (input valid, depth, valid_req, output ready);
endinterface

[hw/rtl/dbas_res_if.sv]
// ----------------------------------------------------------------------------
// dbas_res_if
// Result channel: one half resolution depth pixel per beat.
// ----------------------------------------------------------------------------
interface dbas_res_if;
    logic                           valid;
    logic                           ready;
    logic [dbas_pkg::DEPTH_BITS-1:0] depth_out;
    logic                           valid_out;
    logic                           frame_end;

    modport source (output valid, depth_out, valid_out, frame_end, input ready);
    modport sink   (input valid, depth_out, valid_out, frame_end, output ready);
endinterface

[hw/rtl/dbas_cfg_if.sv]
// ----------------------------------------------------------------------------
// dbas_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface dbas_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dbas_pkg::CFG_IDX_BITS-1:0]  index;
    logic [dbas_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dbas_line_mem.sv]
// ----------------------------------------------------------------------------
// dbas_line_mem
// Line buffer RAM holding the two previous rows per column, one write and
// one registered read port.
// ----------------------------------------------------------------------------
module dbas_line_mem (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [dbas_pkg::ADDR_BITS-1:0]      i_rd_addr,
    output dbas_pkg::t_line_word                o_rd_data,
    input  logic                                i_wr_en,
    input  logic [dbas_pkg::ADDR_BITS-1:0]      i_wr_addr,
    input  dbas_pkg::t_line_word                i_wr_data
);

    dbas_pkg::t_line_word r_mem [dbas_pkg::MAX_WIDTH];
    dbas_pkg::t_line_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/dbas_div.sv]
// ----------------------------------------------------------------------------
// dbas_div
// Two stage divider for window sums by counts 1..9: reciprocal multiply,
// then one remainder correction step.
// ----------------------------------------------------------------------------
module dbas_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dbas_pkg::t_div_req i_req,
    output dbas_pkg::t_div_rsp o_rsp
);

    localparam int PROD_BITS = dbas_pkg::SUM_BITS + dbas_pkg::RECIP_BITS;
    localparam int QC_BITS   = dbas_pkg::SUM_BITS + dbas_pkg::CNT_BITS;

    logic                          r_s1_vld;
    logic [dbas_pkg::SUM_BITS-1:0] r_s1_sum;
    logic [dbas_pkg::CNT_BITS-1:0] r_s1_cnt;
    logic [dbas_pkg::SUM_BITS-1:0] r_s1_q;
    logic                          r_s2_vld;
    logic [dbas_pkg::DEPTH_BITS-1:0] r_s2_q;

    logic [PROD_BITS-1:0]          prod;
    logic [QC_BITS-1:0]            qc;
    logic [dbas_pkg::SUM_BITS-1:0] rem;
    logic [dbas_pkg::SUM_BITS-1:0] q_fix;

    // estimate, never above the true quotient and at most one below
    assign prod = PROD_BITS'(i_req.sum) * PROD_BITS'(dbas_pkg::f_recip(i_req.cnt));

    // remainder check and correction
    assign qc    = QC_BITS'(r_s1_q) * QC_BITS'(r_s1_cnt);
    assign rem   = r_s1_sum - qc[dbas_pkg::SUM_BITS-1:0];
    assign q_fix = (rem >= dbas_pkg::SUM_BITS'(r_s1_cnt)) ? r_s1_q + 1'b1 : r_s1_q;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    // data stages hold until the next request
    always_ff @(posedge i_clk) begin
        if (i_req.vld) begin
            r_s1_sum <= i_req.sum;
            r_s1_cnt <= i_req.cnt;
            r_s1_q   <= prod[dbas_pkg::RECIP_SHIFT +: dbas_pkg::SUM_BITS];
        end
        if (r_s1_vld) begin
            r_s2_q <= q_fix[dbas_pkg::DEPTH_BITS-1:0];
        end
    end

    assign o_rsp.vld  = r_s2_vld;
    assign o_rsp.quot = r_s2_q;

endmodule

[hw/rtl/depth_block_average_subsample_unit.sv]
// ----------------------------------------------------------------------------
// depth_block_average_subsample_unit
// Flow: the beat of pixel (r+1,c+1) passes the line RAM read-modify-write,
// the sum stage, the two divider stages and the output load before its
// result is on the output; a beat with no result only passes the RAM step.
// A new pixel is taken only once the last one is through.
// Reset: counters, window columns and output clear, registers take their
// defaults; the line RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module depth_block_average_subsample_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbas_pix_if.sink    i_pix,
    dbas_res_if.source  o_res,
    dbas_cfg_if.sink    i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIVA = 3'd3;
    localparam logic [2:0] S_DIVB = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int PB = dbas_pkg::POS_BITS;
    localparam int DB = dbas_pkg::DEPTH_BITS;

    logic [2:0]                     r_state, n_state;
    logic [dbas_pkg::ADDR_BITS-1:0] r_col;
    logic [dbas_pkg::ROW_BITS-1:0]  r_row;
    logic [dbas_pkg::DIM_BITS-1:0]  r_img_w;
    logic [dbas_pkg::DIM_BITS-1:0]  r_img_h;
    logic [dbas_pkg::DIST_BITS-1:0] r_max_dist;
    dbas_pkg::t_pix                 r_wc [dbas_pkg::WIN_COLS];

    dbas_pkg::t_pix                 r_cur;
    logic [dbas_pkg::ADDR_BITS-1:0] r_x;
    logic                           r_emit;
    logic                           r_fend;
    logic                           r_top_ok;
    logic                           r_left_ok;

    logic [DB-1:0]                  r_term [dbas_pkg::WIN_SIZE];
    logic                           r_inc  [dbas_pkg::WIN_SIZE];
    logic                           r_cvalid;
    logic [dbas_pkg::SUM_BITS-1:0]  r_sum;
    logic [dbas_pkg::CNT_BITS-1:0]  r_cnt;

    logic                           r_out_vld;
    logic [DB-1:0]                  r_out_dep;
    logic                           r_out_vout;
    logic                           r_out_fend;

    logic                           pix_acc;
    logic                           out_load;
    logic [PB-1:0]                  w_eff, h_eff, w_ext, h_ext;
    logic [PB-1:0]                  col_ext, row_ext;
    logic [PB-1:0]                  w_last, h_last;

    dbas_pkg::t_line_word           mem_rd;
    dbas_pkg::t_line_word           mem_wr;
    dbas_pkg::t_pix                 win [dbas_pkg::WIN_SIZE];
    logic [DB-1:0]                  v_term [dbas_pkg::WIN_SIZE];
    logic                           v_inc  [dbas_pkg::WIN_SIZE];
    logic [DB-1:0]                  v_diff;
    logic [dbas_pkg::SUM_BITS-1:0]  v_sum;
    logic [dbas_pkg::CNT_BITS-1:0]  v_cnt;

    dbas_pkg::t_div_req             div_req;
    dbas_pkg::t_div_rsp             div_rsp;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_OUT) && (!r_out_vld || o_res.ready);

    // clamped frame size and last odd positions
    assign w_ext   = PB'(r_img_w);
    assign h_ext   = PB'(r_img_h);
    assign w_eff   = (w_ext < PB'(2)) ? PB'(2) :
                     (w_ext > PB'(dbas_pkg::MAX_WIDTH)) ? PB'(dbas_pkg::MAX_WIDTH) : w_ext;
    assign h_eff   = (h_ext < PB'(2)) ? PB'(2) :
                     (h_ext > PB'(dbas_pkg::MAX_HEIGHT)) ? PB'(dbas_pkg::MAX_HEIGHT) : h_ext;
    assign w_last  = {w_eff[PB-1:1], 1'b0} - 1'b1;
    assign h_last  = {h_eff[PB-1:1], 1'b0} - 1'b1;
    assign col_ext = PB'(r_col);
    assign row_ext = PB'(r_row);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= dbas_pkg::RST_IMAGE_WIDTH;
            r_img_h    <= dbas_pkg::RST_IMAGE_HEIGHT;
            r_max_dist <= dbas_pkg::RST_MAX_DISTANCE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dbas_pkg::CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg.data[dbas_pkg::DIM_BITS-1:0];
                dbas_pkg::CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg.data[dbas_pkg::DIM_BITS-1:0];
                dbas_pkg::CFG_MAX_DISTANCE: r_max_dist <= i_cfg.data[dbas_pkg::DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // line buffer, read on the accepted beat, written back in the read state that follows
    assign mem_wr.upper  = mem_rd.middle;
    assign mem_wr.middle = r_cur;

    dbas_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (pix_acc),
        .i_rd_addr (r_col),
        .o_rd_data (mem_rd),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_x),
        .i_wr_data (mem_wr)
    );

    // 3x3 window, row-major: older columns from the shift registers, newest from RAM and the current pixel
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win[i*3]     = r_wc[i];
            win[i*3 + 1] = r_wc[3 + i];
        end
        win[2] = mem_rd.upper;
        win[5] = mem_rd.middle;
        win[8] = r_cur;
    end

    // neighbour selection against the centre
    always_comb begin
        v_diff = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                v_diff = (win[i*3 + j].dep > r_wc[4].dep) ? win[i*3 + j].dep - r_wc[4].dep
                                                          : r_wc[4].dep - win[i*3 + j].dep;
                v_inc[i*3 + j] = win[i*3 + j].vld && (v_diff <= r_max_dist) &&
                                 ((i != 0) || r_top_ok) && ((j != 0) || r_left_ok);
                v_term[i*3 + j] = v_inc[i*3 + j] ? win[i*3 + j].dep : '0;
            end
        end
    end

    // window sum and count
    always_comb begin
        v_sum = '0;
        v_cnt = '0;
        for (int k = 0; k < dbas_pkg::WIN_SIZE; k++) begin
            v_sum = v_sum + dbas_pkg::SUM_BITS'(r_term[k]);
            v_cnt = v_cnt + dbas_pkg::CNT_BITS'(r_inc[k]);
        end
    end

    // divider
    assign div_req.vld = (r_state == S_DIVA);
    assign div_req.sum = r_sum;
    assign div_req.cnt = r_cnt;

    dbas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (pix_acc) n_state = S_READ;
            S_READ:  n_state = r_emit ? S_SUM : S_IDLE;
            S_SUM:   n_state = S_DIVA;
            S_DIVA:  n_state = S_DIVB;
            S_DIVB:  n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state: sequencer, position counters, window columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int k = 0; k < dbas_pkg::WIN_COLS; k++) begin
                r_wc[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (pix_acc) begin
                if (col_ext + 1'b1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= (row_ext + 1'b1 >= h_eff) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_state == S_READ) begin
                r_wc[0] <= r_wc[3];
                r_wc[1] <= r_wc[4];
                r_wc[2] <= r_wc[5];
                r_wc[3] <= mem_rd.upper;
                r_wc[4] <= mem_rd.middle;
                r_wc[5] <= r_cur;
            end
        end
    end

    // per beat payload: pixel, position flags, window terms, sums
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_cur.vld <= i_pix.valid_req;
            r_cur.dep <= i_pix.depth;
            r_x       <= r_col;
            r_emit    <= r_col[0] && r_row[0] && (col_ext < w_eff) && (row_ext < h_eff);
            r_fend    <= (row_ext == h_last) && (col_ext == w_last);
            r_top_ok  <= (r_row > dbas_pkg::ROW_BITS'(1));
            r_left_ok <= (r_col > dbas_pkg::ADDR_BITS'(1));
        end
        if (r_state == S_READ) begin
            for (int k = 0; k < dbas_pkg::WIN_SIZE; k++) begin
                r_term[k] <= v_term[k];
                r_inc[k]  <= v_inc[k];
            end
            r_cvalid <= r_wc[4].vld;
        end
        if (r_state == S_SUM) begin
            r_sum <= v_sum;
            r_cnt <= (v_cnt == '0) ? dbas_pkg::CNT_BITS'(1) : v_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dep  <= r_cvalid ? div_rsp.quot : '0;
            r_out_vout <= r_cvalid;
            r_out_fend <= r_fend;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.depth_out = r_out_dep;
    assign o_res.valid_out = r_out_vout;
    assign o_res.frame_end = r_out_fend;

    // the RAM read data is consumed only right after an accepted beat
    a_read_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(i_pix.valid && i_pix.ready))
        else $error("line buffer consumed without an accepted pixel");

    // the divider answers in time for the output state
    a_div_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVB) |=> div_rsp.vld)
        else $error("divider result late");

    // a new result appears only from the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

endmodule
